// ----- hw/rtl/ue2u_pkg.sv -----
// Shared types and constants for the backslash-u escape to UTF-8 converter.
// No dependencies.
package ue2u_pkg;

  localparam int MaxOut = 5;
  localparam int CntW   = 3;

  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharU      = 8'h75;

  typedef enum logic [2:0] {
    PH_PLAIN   = 3'b001,
    PH_SLASH   = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

  // Result bytes of one input item, emitted in order from entry 0.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
    logic                   last;
  } bundle_t;

endpackage

// ----- hw/rtl/ue2u_decode.sv -----
// Escape tracker: holds the escape state and turns one input byte into a result bundle.
// Depends on ue2u_pkg.
module ue2u_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output ue2u_pkg::bundle_t bundle
);

  ue2u_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic        hex_r, hex_nxt;
  logic [7:0]  held_r [4];

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  logic [4:0]  hv;
  logic [15:0] cp_acc;
  logic        hex_acc;

  always_comb begin
    hv      = hex_value(byte_i);
    hex_acc = hex_r & hv[4];
    cp_acc  = hex_acc ? {cp_r[11:0], hv[3:0]} : cp_r;
  end

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    cp_nxt       = cp_r;
    hex_nxt      = hex_r;
    bundle.bytes = '0;
    bundle.cnt   = '0;
    bundle.last  = last_i;
    unique case (phase_r)
      ue2u_pkg::PH_SLASH: begin
        if (byte_i == ue2u_pkg::CharU) begin
          phase_nxt = ue2u_pkg::PH_COLLECT;
          cnt_nxt   = 2'd0;
          cp_nxt    = 16'd0;
          hex_nxt   = 1'b1;
          if (last_i) begin
            bundle.bytes[0] = ue2u_pkg::CharBslash;
            bundle.bytes[1] = ue2u_pkg::CharU;
            bundle.cnt      = 3'd2;
          end
        end else begin
          bundle.bytes[0] = ue2u_pkg::CharBslash;
          if (byte_i == ue2u_pkg::CharBslash && !last_i) begin
            bundle.cnt = 3'd1;
          end else begin
            bundle.bytes[1] = byte_i;
            bundle.cnt      = 3'd2;
            phase_nxt       = ue2u_pkg::PH_PLAIN;
          end
        end
      end
      ue2u_pkg::PH_COLLECT: begin
        cp_nxt  = cp_acc;
        hex_nxt = hex_acc;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          if (cp_acc[15:11] != 5'd0) begin
            bundle.bytes[0] = {4'hE, cp_acc[15:12]};
            bundle.bytes[1] = {2'b10, cp_acc[11:6]};
            bundle.bytes[2] = {2'b10, cp_acc[5:0]};
            bundle.cnt      = 3'd3;
          end else if (cp_acc[15:7] != 9'd0) begin
            bundle.bytes[0] = {3'b110, cp_acc[10:6]};
            bundle.bytes[1] = {2'b10, cp_acc[5:0]};
            bundle.cnt      = 3'd2;
          end else begin
            bundle.bytes[0] = cp_acc[7:0];
            bundle.cnt      = 3'd1;
          end
          phase_nxt = ue2u_pkg::PH_PLAIN;
          cnt_nxt   = 2'd0;
          cp_nxt    = 16'd0;
          hex_nxt   = 1'b1;
        end else if (last_i) begin
          // escape cut short: flush it unchanged
          bundle.bytes[0] = ue2u_pkg::CharBslash;
          bundle.bytes[1] = ue2u_pkg::CharU;
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < cnt_r) bundle.bytes[2+i] = held_r[i];
            else if (2'(i) == cnt_r) bundle.bytes[2+i] = byte_i;
          end
          bundle.cnt = 3'd3 + {1'b0, cnt_r};
        end
      end
      default: begin
        if (byte_i == ue2u_pkg::CharBslash && !last_i) begin
          phase_nxt = ue2u_pkg::PH_SLASH;
        end else begin
          bundle.bytes[0] = byte_i;
          bundle.cnt      = 3'd1;
          phase_nxt       = ue2u_pkg::PH_PLAIN;
        end
      end
    endcase
    if (last_i) begin
      phase_nxt = ue2u_pkg::PH_PLAIN;
      cnt_nxt   = 2'd0;
      cp_nxt    = 16'd0;
      hex_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ue2u_pkg::PH_PLAIN;
      cnt_r   <= 2'd0;
      cp_r    <= 16'd0;
      hex_r   <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cp_r    <= cp_nxt;
      hex_r   <= hex_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && phase_r == ue2u_pkg::PH_COLLECT) begin
      held_r[cnt_r] <= byte_i;
    end
  end

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != ue2u_pkg::PH_COLLECT |-> cnt_r == 2'd0 && cp_r == 16'd0)
    else $error("digit count or code point nonzero outside an escape");
  a_hex_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !hex_r |-> phase_r == ue2u_pkg::PH_COLLECT && cnt_r != 2'd0)
    else $error("non-hex flag set outside a started escape");
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_i |=> phase_r == ue2u_pkg::PH_PLAIN && cnt_r == 2'd0)
    else $error("state not cleared after end of text");

endmodule

// ----- hw/rtl/ue2u_serializer.sv -----
// Output serializer: holds one result bundle and sends it one byte per transfer.
// Depends on ue2u_pkg.
module ue2u_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ue2u_pkg::bundle_t bundle,
  output logic              can_load,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  logic [ue2u_pkg::MaxOut-1:0][7:0] buf_r, buf_nxt;
  logic [ue2u_pkg::CntW-1:0]        cnt_r, cnt_nxt;
  logic                             last_r, last_nxt;
  logic                             take;

  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = buf_r[0];
  assign out_tlast  = last_r && cnt_r == ue2u_pkg::CntW'(1);
  assign take       = out_tvalid && out_tready;
  assign can_load   = cnt_r == '0 || (cnt_r == ue2u_pkg::CntW'(1) && out_tready);

  always_comb begin
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (load) begin
      buf_nxt  = bundle.bytes;
      cnt_nxt  = bundle.cnt;
      last_nxt = bundle.last;
    end else if (take) begin
      buf_nxt = {8'h00, buf_r[ue2u_pkg::MaxOut-1:1]};
      cnt_nxt = cnt_r - ue2u_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    last_r <= last_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ue2u_pkg::CntW'(ue2u_pkg::MaxOut))
    else $error("serializer count out of range");
  a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load && bundle.cnt <= ue2u_pkg::CntW'(ue2u_pkg::MaxOut))
    else $error("bundle loaded over pending bytes");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    take && !load |=> cnt_r == $past(cnt_r) - ue2u_pkg::CntW'(1))
    else $error("serializer count did not step down on transfer");

endmodule

// ----- hw/rtl/unicode_escape_to_utf8.sv -----
// Backslash-u escape to UTF-8 converter, top level.
// Byte stream in, byte stream out, one byte per transfer on each side.
// Input: in_tdata carries the text byte, in_tlast marks the final byte of the text.
// Output: out_tdata carries a converted byte, out_tlast marks the final output byte.
// Plain bytes are copied; a backslash, 'u' and four characters become 1 to 3
// UTF-8 bytes of the code point given by the leading hex digits. An escape cut
// short by in_tlast is flushed unchanged.
// Datapath: input register, decode logic, output serializer.
// A plain byte passes the input register and then the serializer buffer on
// its way from its input transfer to out_tdata.
// Throughput: one input byte per cycle while each byte gives at most one
// output byte and the receiver does not stall; an item with more output
// bytes holds the serializer until all are sent, which is the rate limit.
// The input register takes one more byte while the serializer waits on
// a stalled receiver. Reset clears all handshake and escape state; held
// escape characters are not reset. A stalled receiver holds
// out_tdata/out_tlast and fills the input register, after which in_tready drops.
module unicode_escape_to_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       can_load;
  logic       step;
  ue2u_pkg::bundle_t bundle;

  assign step      = in_valid_r && can_load;
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  ue2u_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .byte_i (in_byte_r),
    .last_i (in_last_r),
    .bundle (bundle)
  );

  ue2u_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .bundle     (bundle),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for unicode_escape_to_utf8: stream texts in, check every output byte.
// A scoreboard class predicts the converted bytes; uses ue2u_pkg for the phase enum and chars.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  function automatic byte_q_t with_char(byte_q_t q, logic [7:0] b);
    q.insert(q.size(), b);
    return q;
  endfunction

  class Utf8Scoreboard;
    ue2u_pkg::phase_t mode;
    logic [2:0] n_held;
    logic [15:0] cp_acc;
    bit         all_hex;
    logic [7:0] held[4];
    logic [7:0] res[5];
    int         n_res;
    beat_t      exp_q[$];
    int         errors;
    int         checked;

    function new();
      clear_escape();
      errors  = 0;
      checked = 0;
      n_res   = 0;
    endfunction

    function void clear_escape();
      mode    = ue2u_pkg::PH_PLAIN;
      n_held  = 3'd0;
      cp_acc  = 16'h0000;
      all_hex = 1'b1;
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    function void emit(logic [7:0] b);
      res[n_res] = b;
      n_res++;
    endfunction

    function void add_exp(beat_t e);
      exp_q.insert(exp_q.size(), e);
    endfunction

    // Predict the bytes caused by one accepted input transfer.
    function void note_input(logic [7:0] c, logic is_last);
      int         v;
      logic [1:0] k;
      beat_t      e;
      n_res = 0;
      case (mode)
        ue2u_pkg::PH_SLASH: begin
          if (c == ue2u_pkg::CharU) begin
            mode    = ue2u_pkg::PH_COLLECT;
            n_held  = 3'd0;
            cp_acc  = 16'h0000;
            all_hex = 1'b1;
            if (is_last) begin
              emit(ue2u_pkg::CharBslash);
              emit(ue2u_pkg::CharU);
            end
          end else begin
            emit(ue2u_pkg::CharBslash);
            if (c == ue2u_pkg::CharBslash && !is_last) begin
              mode = ue2u_pkg::PH_SLASH;
            end else begin
              emit(c);
              mode = ue2u_pkg::PH_PLAIN;
            end
          end
        end
        ue2u_pkg::PH_COLLECT: begin
          v = nibble_of(c);
          k = n_held[1:0];
          held[k] = c;
          if (all_hex && v >= 0) cp_acc = {cp_acc[11:0], v[3:0]};
          else all_hex = 1'b0;
          n_held = {1'b0, k} + 3'd1;
          if (n_held == 3'd4) begin
            if (cp_acc > 16'h07FF) begin
              emit({4'hE, cp_acc[15:12]});
              emit({2'b10, cp_acc[11:6]});
              emit({2'b10, cp_acc[5:0]});
            end else if (cp_acc > 16'h007F) begin
              emit({3'b110, cp_acc[10:6]});
              emit({2'b10, cp_acc[5:0]});
            end else begin
              emit(cp_acc[7:0]);
            end
            clear_escape();
          end else if (is_last) begin
            emit(ue2u_pkg::CharBslash);
            emit(ue2u_pkg::CharU);
            for (int i = 0; i < int'(n_held); i++) emit(held[i]);
          end
        end
        default: begin
          if (c == ue2u_pkg::CharBslash && !is_last) begin
            mode = ue2u_pkg::PH_SLASH;
          end else begin
            emit(c);
            mode = ue2u_pkg::PH_PLAIN;
          end
        end
      endcase
      for (int i = 0; i < n_res; i++) begin
        e.data = res[i];
        e.last = is_last && (i == n_res - 1);
        add_exp(e);
      end
      if (is_last) clear_escape();
    endfunction

    function void check_output(logic [7:0] data, logic last);
      beat_t e;
      checked++;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected output transfer data %02h last %0b", $time, data, last);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      if (data !== e.data) begin
        $display("%0t: out_tdata mismatch expected %02h actual %02h", $time, e.data, data);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: out_tlast mismatch expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return exp_q.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic       out_tlast;

  Utf8Scoreboard sb = new();

  int idle_pct  = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int texts_sent = 0;

  unicode_escape_to_utf8 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_text(input byte_q_t txt);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
    texts_sent++;
  endtask

  task automatic send_str(input string s);
    byte_q_t txt;
    for (int i = 0; i < s.len(); i++) txt = with_char(txt, s[i]);
    send_text(txt);
  endtask

  // Hold the input idle until every predicted byte has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task automatic build_text(output byte_q_t txt);
    string hexchars;
    int    segs;
    int    cut;
    logic [7:0] d;
    hexchars = "0123456789abcdefABCDEF";
    txt = {};
    segs = $urandom_range(4, 1);
    for (int s = 0; s < segs; s++) begin
      case ($urandom_range(9)) inside
        [0:4]: begin
          txt = with_char(txt, ue2u_pkg::CharBslash);
          txt = with_char(txt, ue2u_pkg::CharU);
          cut = $urandom_range(2);
          for (int i = 0; i < 4; i++) begin
            if (i < 2 - cut) d = "0";
            else d = hexchars[$urandom_range(21)];
            if ($urandom_range(9) == 0) d = 8'($urandom_range(255));
            txt = with_char(txt, d);
          end
        end
        [5:6]: txt = with_char(txt, 8'($urandom_range(255)));
        7: begin
          txt = with_char(txt, ue2u_pkg::CharBslash);
          txt = with_char(txt, 8'($urandom_range(255)));
        end
        8: txt = with_char(txt, 8'($urandom_range(126, 32)));
        default: begin
          txt = with_char(txt, ue2u_pkg::CharBslash);
          if ($urandom_range(3) != 0) begin
            txt = with_char(txt, ue2u_pkg::CharU);
            cut = $urandom_range(3);
            for (int i = 0; i < cut; i++) txt = with_char(txt, hexchars[$urandom_range(21)]);
          end
          break;
        end
      endcase
    end
  endtask

  initial begin
    byte_q_t txt;
    int      phase_start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, backslash cases, each encoding length,
    // non-hex run stop, escape cut short, lone trailing backslash.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_str("\\\\x");
    send_str("\\u007f");
    send_str("\\u00e9");
    send_str("\\uFFFF");
    send_str("\\uABg1");
    send_str("\\u12");
    send_str("\\");
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 30) begin
        build_text(txt);
        send_text(txt);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Covered %0d input bytes in %0d texts, %0d output bytes checked,", bytes_sent,
             texts_sent, sb.checked);
    $display("under free flow, sender gaps, receiver stalls and both combined.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ue2u_pkg.sv
hw/rtl/ue2u_decode.sv
hw/rtl/ue2u_serializer.sv
hw/rtl/unicode_escape_to_utf8.sv
verif/tb_top.sv
